// ===== design/rcbp_pkg.sv =====
// shared sizes, opcodes and status codes for the reader counted buffer publisher
`timescale 1ns / 1ps
package rcbp_pkg;

  localparam int SLOT_COUNT        = 4;
  localparam int READER_COUNT_BITS = 8;
  localparam int DESCRIPTOR_BITS   = 64;

  localparam int SLOT_BITS   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int OP_BITS     = 2;
  localparam int STATUS_BITS = 2;
  localparam int PORT_SLOT_BITS = 2;
  localparam int PORT_DESC_BITS = 64;

  typedef logic [SLOT_BITS-1:0]         slot_idx_t;
  typedef logic [READER_COUNT_BITS-1:0] reader_cnt_t;
  typedef logic [DESCRIPTOR_BITS-1:0]   desc_t;

  typedef enum logic [OP_BITS-1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PUBLISH = 2'd2,
    OP_UNUSED  = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_DONE    = 2'd0,
    ST_NO_SLOT = 2'd1,
    ST_COUNT   = 2'd2
  } status_t;

endpackage

// ===== design/reader_counted_buffer_publisher_unit.sv =====
// top level: reader counted slot publisher with descriptor memory
//
//  channel | ports                                               | direction
//  --------+-----------------------------------------------------+----------
//  command | start, busy (out), in_opcode, in_release_slot,      | in
//          | in_descriptor_in                                    |
//  result  | out_valid, out_status, out_slot_out,                | out
//          | out_descriptor_out                                  |
//
//  one word accepted per cycle while busy is low; its result appears in the next cycle for one cycle
//  latency is set by the registered read port of the descriptor memory
//  busy is high only in the cycle after a reset cycle
//  reset clears the published slot, all reader counts and the slot zero valid flag
//  results cannot be held off by the receiver
`timescale 1ns / 1ps
module reader_counted_buffer_publisher_unit
  import rcbp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [OP_BITS-1:0]        in_opcode,
  input  logic [PORT_SLOT_BITS-1:0] in_release_slot,
  input  logic [PORT_DESC_BITS-1:0] in_descriptor_in,
  output logic                      out_valid,
  output logic [STATUS_BITS-1:0]    out_status,
  output logic [PORT_SLOT_BITS-1:0] out_slot_out,
  output logic [PORT_DESC_BITS-1:0] out_descriptor_out
);

  desc_t       desc_mem [SLOT_COUNT];
  desc_t       rd_data_r;

  reader_cnt_t cnt_r   [SLOT_COUNT];
  reader_cnt_t cnt_nxt [SLOT_COUNT];
  slot_idx_t   pub_r, pub_nxt;
  logic        slot0_vld_r, slot0_vld_nxt;
  logic        busy_r;

  logic                      valid_r;
  status_t                   status_r, status_nxt;
  logic [PORT_SLOT_BITS-1:0] slot_r, slot_nxt;
  logic                      desc_en_r, desc_en_nxt;
  logic                      zero_rd_r, zero_rd_nxt;

  logic      accept;
  logic      mem_we;
  slot_idx_t mem_waddr;
  desc_t     mem_wdata;

  slot_idx_t rel_idx;
  logic      rel_oor;
  logic      found;
  slot_idx_t cand_sel;
  logic [SLOT_BITS:0] cand_sum;

  assign accept    = start && !busy;
  assign rel_idx   = SLOT_BITS'(in_release_slot);
  assign rel_oor   = (32'(in_release_slot) >= 32'(SLOT_COUNT));
  assign mem_wdata = DESCRIPTOR_BITS'(in_descriptor_in);

  // rotating search for a free slot after the published one
  always_comb begin
    found    = 1'b0;
    cand_sel = pub_r;
    cand_sum = '0;
    for (int off = SLOT_COUNT - 1; off >= 1; off--) begin
      cand_sum = {1'b0, pub_r} + (SLOT_BITS + 1)'(off);
      if (cand_sum >= (SLOT_BITS + 1)'(SLOT_COUNT)) begin
        cand_sum = cand_sum - (SLOT_BITS + 1)'(SLOT_COUNT);
      end
      if (cnt_r[cand_sum[SLOT_BITS-1:0]] == '0) begin
        found    = 1'b1;
        cand_sel = cand_sum[SLOT_BITS-1:0];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      cnt_nxt[i] = cnt_r[i];
    end
    pub_nxt       = pub_r;
    slot0_vld_nxt = slot0_vld_r;
    status_nxt    = ST_DONE;
    slot_nxt      = PORT_SLOT_BITS'(pub_r);
    desc_en_nxt   = 1'b0;
    zero_rd_nxt   = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = cand_sel;
    case (opcode_t'(in_opcode))
      OP_ACQUIRE: begin
        if (&cnt_r[pub_r]) begin
          status_nxt = ST_COUNT;
        end else begin
          cnt_nxt[pub_r] = cnt_r[pub_r] + 1'b1;
          desc_en_nxt    = 1'b1;
          zero_rd_nxt    = (pub_r == '0) && !slot0_vld_r;
        end
      end
      OP_RELEASE: begin
        slot_nxt = in_release_slot;
        if (rel_oor || cnt_r[rel_idx] == '0) begin
          status_nxt = ST_COUNT;
        end else begin
          cnt_nxt[rel_idx] = cnt_r[rel_idx] - 1'b1;
        end
      end
      OP_PUBLISH: begin
        if (found) begin
          mem_we   = accept;
          pub_nxt  = cand_sel;
          slot_nxt = PORT_SLOT_BITS'(cand_sel);
          if (cand_sel == '0) begin
            slot0_vld_nxt = 1'b1;
          end
        end else begin
          status_nxt = ST_NO_SLOT;
        end
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
  end

  // descriptor memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      desc_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= desc_mem[pub_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        cnt_r[i] <= '0;
      end
      pub_r       <= '0;
      slot0_vld_r <= 1'b0;
      valid_r     <= 1'b0;
      busy_r      <= 1'b1;
    end else begin
      busy_r  <= 1'b0;
      valid_r <= accept;
      if (accept) begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          cnt_r[i] <= cnt_nxt[i];
        end
        pub_r       <= pub_nxt;
        slot0_vld_r <= slot0_vld_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      slot_r    <= slot_nxt;
      desc_en_r <= desc_en_nxt;
      zero_rd_r <= zero_rd_nxt;
    end
  end

  assign busy               = busy_r;
  assign out_valid          = valid_r;
  assign out_status         = status_r;
  assign out_slot_out       = slot_r;
  assign out_descriptor_out = (desc_en_r && !zero_rd_r) ?
                              PORT_DESC_BITS'(rd_data_r) : '0;

endmodule
